// File: rtl/core/led_frame_pwm_dimmer_defines.svh
// Assertion macros shared by the dimmer RTL.
// Expects signals clk and rst_n in the scope of each use; no other dependencies.
`ifndef LED_FRAME_PWM_DIMMER_DEFINES_SVH
`define LED_FRAME_PWM_DIMMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define LFPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lfpd_pkg.sv
// Package for the LED frame PWM dimmer: sizes, operation and command codes, types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lfpd_pkg;

  // Chain size and PWM depth
  localparam int NUM_LEDS  = 25;
  localparam int PWM_STEPS = 16;

  // Field widths
  localparam int OP_W      = 3;
  localparam int IDX_IN_W  = 6;
  localparam int CH_W      = 8;
  localparam int LEVEL_W   = 8;
  localparam int OUT_POS_W = 6;
  localparam int IDX_CMP_W = IDX_IN_W + 1;
  localparam int LED_IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  // Operation codes on in_operation
  localparam logic [OP_W-1:0] OP_SET_COLOUR = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_LEVEL  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd2;
  localparam logic [OP_W-1:0] OP_DIMMED     = 3'd3;
  localparam logic [OP_W-1:0] OP_PLAIN      = 3'd4;

  // Command kinds carried through the queue
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_SET_COLOUR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_LEVEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FRAME      = 2'd3;

  // Command queue, depth a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } lfpd_rgb_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic                 dimmed;
    logic [LED_IDX_W-1:0] index;
    lfpd_rgb_t            colour;
    logic [LEVEL_W-1:0]   level;
  } lfpd_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lfpd_q_status_t;

endpackage

// File: rtl/core/lfpd_cmd_fifo.sv
// Command queue between the decode front and the execution back of the dimmer.
// Depends on lfpd_pkg and the dimmer assertion macro header.
`timescale 1ns / 1ps
`include "led_frame_pwm_dimmer_defines.svh"

module lfpd_cmd_fifo import lfpd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lfpd_cmd_t      push_cmd,
  input  logic           pop,
  output lfpd_cmd_t      head_cmd,
  output lfpd_q_status_t q_status
);

  lfpd_cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r;
  logic [FIFO_CNT_W-1:0]   count_nxt;

  assign q_status.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign head_cmd       = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + FIFO_CNT_W'(1);
      2'b01:   count_nxt = count_r - FIFO_CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  `LFPD_ASSERT_SAME(a_no_overflow, push && !pop, !q_status.full, "queue push while full")
  `LFPD_ASSERT_SAME(a_no_underflow, pop, !q_status.empty, "queue pop while empty")

endmodule

// File: rtl/core/lfpd_front.sv
// Front end of the dimmer: takes command transactions, decodes and filters them,
// clamps levels and hands commands to the queue. Depends on lfpd_pkg.
`timescale 1ns / 1ps

module lfpd_front import lfpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [IDX_IN_W-1:0]  in_led_index,
  input  logic [CH_W-1:0]      in_red_in,
  input  logic [CH_W-1:0]      in_green_in,
  input  logic [CH_W-1:0]      in_blue_in,
  input  logic [LEVEL_W-1:0]   in_level_in,
  input  lfpd_q_status_t       q_status,
  output logic                 push,
  output lfpd_cmd_t            push_cmd
);

  logic      stage_valid_r;
  logic      stage_valid_nxt;
  lfpd_cmd_t stage_r;
  lfpd_cmd_t dec_cmd;
  logic      dec_keep;
  logic      idx_ok;
  logic      accept;

  assign busy     = stage_valid_r && q_status.full;
  assign accept   = start && !busy;
  assign push     = stage_valid_r && !q_status.full;
  assign push_cmd = stage_r;

  assign idx_ok = ({1'b0, in_led_index} < IDX_CMP_W'(NUM_LEDS));

  // decode: drop unknown operations and out-of-range writes
  always_comb begin
    dec_cmd.kind          = KIND_CLEAR;
    dec_cmd.dimmed        = 1'b0;
    dec_cmd.index         = in_led_index[LED_IDX_W-1:0];
    dec_cmd.colour.red    = in_red_in;
    dec_cmd.colour.green  = in_green_in;
    dec_cmd.colour.blue   = in_blue_in;
    dec_cmd.level         = (in_level_in > LEVEL_W'(PWM_STEPS)) ? LEVEL_W'(PWM_STEPS)
                                                                : in_level_in;
    dec_keep              = 1'b0;
    unique case (in_operation)
      OP_SET_COLOUR: begin
        dec_cmd.kind = KIND_SET_COLOUR;
        dec_keep     = idx_ok;
      end
      OP_SET_LEVEL: begin
        dec_cmd.kind = KIND_SET_LEVEL;
        dec_keep     = idx_ok;
      end
      OP_CLEAR: begin
        dec_cmd.kind = KIND_CLEAR;
        dec_keep     = 1'b1;
      end
      OP_DIMMED: begin
        dec_cmd.kind   = KIND_FRAME;
        dec_cmd.dimmed = 1'b1;
        dec_keep       = 1'b1;
      end
      OP_PLAIN: begin
        dec_cmd.kind = KIND_FRAME;
        dec_keep     = 1'b1;
      end
      default: dec_keep = 1'b0;
    endcase
  end

  // one-entry staging register ahead of the queue
  assign stage_valid_nxt = (stage_valid_r && !push) || (accept && dec_keep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec_keep) stage_r <= dec_cmd;
  end

endmodule

// File: rtl/core/lfpd_back.sv
// Back end of the dimmer: executes queued commands on the colour and level stores
// and streams frames one LED per cycle. Depends on lfpd_pkg and the macro header.
`timescale 1ns / 1ps
`include "led_frame_pwm_dimmer_defines.svh"

module lfpd_back import lfpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfpd_cmd_t             head_cmd,
  input  lfpd_q_status_t        q_status,
  output logic                  pop,
  output logic                  out_strobe,
  output logic [OUT_POS_W-1:0]  out_led_position,
  output logic [CH_W-1:0]       out_green_out,
  output logic [CH_W-1:0]       out_red_out,
  output logic [CH_W-1:0]       out_blue_out,
  output logic                  out_last_led
);

  localparam logic [0:0] ST_IDLE  = 1'b0;
  localparam logic [0:0] ST_FRAME = 1'b1;

  localparam logic [LED_IDX_W-1:0] LAST_POS = LED_IDX_W'(NUM_LEDS - 1);
  localparam logic [LEVEL_W-1:0]   PWM_TOP  = LEVEL_W'(PWM_STEPS);
  localparam logic [LEVEL_W-1:0]   PHASE_LO = LEVEL_W'(1);

  logic [0:0]           state_r, state_nxt;
  logic [LED_IDX_W-1:0] pos_r, pos_nxt;
  logic                 dimmed_r, dimmed_nxt;
  logic [LEVEL_W-1:0]   phase_r, phase_nxt;

  lfpd_rgb_t            colour_r [NUM_LEDS];
  logic [LEVEL_W-1:0]   level_r  [NUM_LEDS];

  logic                 colour_we;
  logic                 level_we;
  logic                 clear_all;
  logic                 emit;
  logic                 dark;
  lfpd_rgb_t            pixel;

  logic                 out_strobe_r;
  logic [OUT_POS_W-1:0] out_pos_r;
  lfpd_rgb_t            out_rgb_r;
  logic                 out_last_r;

  // sequencer: one command per cycle when idle, one LED per cycle in a frame
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    dimmed_nxt = dimmed_r;
    phase_nxt  = phase_r;
    pop        = 1'b0;
    colour_we  = 1'b0;
    level_we   = 1'b0;
    clear_all  = 1'b0;
    emit       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          unique case (head_cmd.kind)
            KIND_SET_COLOUR: colour_we = 1'b1;
            KIND_SET_LEVEL:  level_we  = 1'b1;
            KIND_CLEAR:      clear_all = 1'b1;
            KIND_FRAME: begin
              state_nxt  = ST_FRAME;
              pos_nxt    = '0;
              dimmed_nxt = head_cmd.dimmed;
            end
            default: ;
          endcase
        end
      end
      ST_FRAME: begin
        emit = 1'b1;
        if (pos_r == LAST_POS) begin
          state_nxt = ST_IDLE;
          // phase counts down after a dimmed frame, wrapping from 1 to the top
          if (dimmed_r) phase_nxt = (phase_r == PHASE_LO) ? PWM_TOP : phase_r - PHASE_LO;
        end else begin
          pos_nxt = pos_r + LED_IDX_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // dimming rule: dark when phase is above the LED's level
  assign dark  = dimmed_r && (phase_r > level_r[pos_r]);
  assign pixel = dark ? '0 : colour_r[pos_r];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      dimmed_r     <= 1'b0;
      phase_r      <= PWM_TOP;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      dimmed_r     <= dimmed_nxt;
      phase_r      <= phase_nxt;
      out_strobe_r <= emit;
    end
  end

  // per-LED stores, cleared by reset; the clear command clears only the colours
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        colour_r[i] <= '0;
        level_r[i]  <= '0;
      end
    end else begin
      if (clear_all) begin
        for (int i = 0; i < NUM_LEDS; i++) colour_r[i] <= '0;
      end
      if (colour_we) colour_r[head_cmd.index] <= head_cmd.colour;
      if (level_we)  level_r[head_cmd.index]  <= head_cmd.level;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_pos_r  <= OUT_POS_W'(pos_r);
      out_rgb_r  <= pixel;
      out_last_r <= (pos_r == LAST_POS);
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_led_position = out_pos_r;
  assign out_green_out    = out_rgb_r.green;
  assign out_red_out      = out_rgb_r.red;
  assign out_blue_out     = out_rgb_r.blue;
  assign out_last_led     = out_last_r;

  `LFPD_ASSERT_SAME(a_last_pos, out_strobe_r && out_last_r, out_pos_r == OUT_POS_W'(NUM_LEDS - 1), "last flag off the final LED")
  `LFPD_ASSERT_NEXT(a_idle_quiet, state_r == ST_IDLE, !out_strobe_r, "result strobe without a frame")

endmodule

// File: rtl/core/led_frame_pwm_dimmer.sv
// Top level of the LED frame PWM dimmer: front decoder, command queue, back executor.
// Depends on lfpd_pkg, lfpd_front, lfpd_cmd_fifo and lfpd_back.
//
//   channel   | handshake        | payload
//   ----------+------------------+----------------------------------------------
//   command   | start / busy     | in_operation, in_led_index, in_*_in, in_level_in
//   result    | out_strobe       | out_led_position, out_*_out, out_last_led
//
// Write, level and clear commands execute in the back end as they are popped.
// A frame is first popped from the queue, then yields one result per LED.
// A staging register plus a FIFO_DEPTH-entry queue let the front take commands
// while a frame streams; busy rises only when both are full.
// Reset is synchronous, active low: stores go to zero, phase to PWM_STEPS.
// Results cannot be held off by the receiver; the strobe marks every valid result.
`timescale 1ns / 1ps

module led_frame_pwm_dimmer import lfpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [IDX_IN_W-1:0]   in_led_index,
  input  logic [CH_W-1:0]       in_red_in,
  input  logic [CH_W-1:0]       in_green_in,
  input  logic [CH_W-1:0]       in_blue_in,
  input  logic [LEVEL_W-1:0]    in_level_in,
  output logic                  out_strobe,
  output logic [OUT_POS_W-1:0]  out_led_position,
  output logic [CH_W-1:0]       out_green_out,
  output logic [CH_W-1:0]       out_red_out,
  output logic [CH_W-1:0]       out_blue_out,
  output logic                  out_last_led
);

  lfpd_q_status_t q_status;
  lfpd_cmd_t      push_cmd;
  lfpd_cmd_t      head_cmd;
  logic           push;
  logic           pop;

  lfpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_led_index (in_led_index),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .in_level_in  (in_level_in),
    .q_status     (q_status),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  lfpd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  lfpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_cmd         (head_cmd),
    .q_status         (q_status),
    .pop              (pop),
    .out_strobe       (out_strobe),
    .out_led_position (out_led_position),
    .out_green_out    (out_green_out),
    .out_red_out      (out_red_out),
    .out_blue_out     (out_blue_out),
    .out_last_led     (out_last_led)
  );

endmodule

// File: dv/tb_led_frame_pwm_dimmer.sv
// Self-checking testbench for led_frame_pwm_dimmer: directed and random commands,
// with a shadow copy of the colour, level and phase state predicting each frame.
// Depends on lfpd_pkg and the led_frame_pwm_dimmer RTL.
`timescale 1ns / 1ps

module tb_led_frame_pwm_dimmer import lfpd_pkg::*;;

  localparam int  HALF_PERIOD  = 6;
  localparam int  RESET_CYCLES = 8;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  RANDOM_CMDS  = 390;
  localparam int  MAX_PRINTS   = 30;
  localparam int  OP_LAST      = (1 << OP_W) - 1;
  localparam int  IDX_LAST     = (1 << IDX_IN_W) - 1;
  localparam int  CH_LAST      = (1 << CH_W) - 1;
  localparam int  LEVEL_LAST   = (1 << LEVEL_W) - 1;

  // One pixel as it leaves the block
  typedef struct packed {
    logic [OUT_POS_W-1:0] pos;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      blue;
    logic                 last;
  } pixel_t;

  // Shadow state of the dimmer plus the queue of pixels still owed
  class dimmer_shadow;
    lfpd_rgb_t          colours [NUM_LEDS];
    logic [LEVEL_W-1:0] levels  [NUM_LEDS];
    logic [LEVEL_W-1:0] phase;
    pixel_t             expected_pixels [$];
    int mismatch_count;
    int pixels_checked;
    int commands_seen;
    int frames_seen;
    int dimmed_seen;
    int phase_wraps;

    function new();
      foreach (colours[i]) begin
        colours[i] = '0;
        levels[i]  = '0;
      end
      phase = LEVEL_W'(PWM_STEPS);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Apply one accepted transaction and queue the pixels it produces
    function void note_command(logic [OP_W-1:0] op, logic [IDX_IN_W-1:0] idx,
                               logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                               logic [CH_W-1:0] b, logic [LEVEL_W-1:0] lvl);
      lfpd_rgb_t c;
      logic      dimmed;
      commands_seen++;
      dimmed = (op == OP_DIMMED);
      case (op)
        OP_SET_COLOUR: begin
          if (int'(idx) < NUM_LEDS) colours[idx] = '{red: r, green: g, blue: b};
        end
        OP_SET_LEVEL: begin
          if (int'(idx) < NUM_LEDS)
            levels[idx] = (int'(lvl) > PWM_STEPS) ? LEVEL_W'(PWM_STEPS) : lvl;
        end
        OP_CLEAR: begin
          foreach (colours[i]) colours[i] = '0;
        end
        OP_DIMMED, OP_PLAIN: begin
          frames_seen++;
          for (int i = 0; i < NUM_LEDS; i++) begin
            c = colours[i];
            // pixel goes dark while the phase sits above its level
            if (dimmed && phase > levels[i]) c = '0;
            expected_pixels.push_back('{pos: OUT_POS_W'(i), green: c.green, red: c.red,
                                       blue: c.blue, last: (i == NUM_LEDS - 1)});
          end
          if (dimmed) begin
            dimmed_seen++;
            phase = phase - 1'b1;
            if (phase == '0) begin
              phase = LEVEL_W'(PWM_STEPS);
              phase_wraps++;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one strobed pixel with the oldest one owed
    task check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %0d with nothing expected", got.pos));
        return;
      end
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (got.pos !== want.pos || got.green !== want.green || got.red !== want.red ||
          got.blue !== want.blue || got.last !== want.last)
        report_mismatch($sformatf(
          "pos %0d/%0d g %02h/%02h r %02h/%02h b %02h/%02h last %0b/%0b (got/exp)",
          got.pos, want.pos, got.green, want.green, got.red, want.red,
          got.blue, want.blue, got.last, want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_operation;
  logic [IDX_IN_W-1:0]  in_led_index;
  logic [CH_W-1:0]      in_red_in;
  logic [CH_W-1:0]      in_green_in;
  logic [CH_W-1:0]      in_blue_in;
  logic [LEVEL_W-1:0]   in_level_in;
  logic                 out_strobe;
  logic [OUT_POS_W-1:0] out_led_position;
  logic [CH_W-1:0]      out_green_out;
  logic [CH_W-1:0]      out_red_out;
  logic [CH_W-1:0]      out_blue_out;
  logic                 out_last_led;

  dimmer_shadow shadow = new();
  int           cycle_count = 0;

  led_frame_pwm_dimmer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_led_index     (in_led_index),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .in_level_in      (in_level_in),
    .out_strobe       (out_strobe),
    .out_led_position (out_led_position),
    .out_green_out    (out_green_out),
    .out_red_out      (out_red_out),
    .out_blue_out     (out_blue_out),
    .out_last_led     (out_last_led)
  );

  // Clock
  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still owed", cycle_count,
               shadow.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Result monitor: every strobe is a transaction, no back-pressure
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      shadow.check_pixel('{pos: out_led_position, green: out_green_out, red: out_red_out,
                           blue: out_blue_out, last: out_last_led});
  end

  // Present one command and hold it until the block takes it
  task issue_command(logic [OP_W-1:0] op, logic [IDX_IN_W-1:0] idx, logic [CH_W-1:0] r,
                     logic [CH_W-1:0] g, logic [CH_W-1:0] b, logic [LEVEL_W-1:0] lvl);
    start        <= 1'b1;
    in_operation <= op;
    in_led_index <= idx;
    in_red_in    <= r;
    in_green_in  <= g;
    in_blue_in   <= b;
    in_level_in  <= lvl;
    do @(posedge clk); while (busy);
    shadow.note_command(op, idx, r, g, b, lvl);
  endtask

  task hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender pause until every owed pixel has come back
  task drain_pixels();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Random command, weighted toward writes that feed frames
  logic [OP_W-1:0]     r_op;
  logic [IDX_IN_W-1:0] r_idx;
  logic [LEVEL_W-1:0]  r_lvl;
  int                  effective;
  int                  burst_left;
  int                  pick;

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_SET_COLOUR;
    in_led_index = '0;
    in_red_in    = '0;
    in_green_in  = '0;
    in_blue_in   = '0;
    in_level_in  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: frames from reset, edge indexes, level clamping, unknown codes
    issue_command(OP_PLAIN, '0, '0, '0, '0, '0);
    issue_command(OP_DIMMED, '0, '0, '0, '0, '0);
    issue_command(OP_SET_COLOUR, '0, 8'hff, 8'h00, 8'ha5, '0);
    issue_command(OP_SET_COLOUR, IDX_IN_W'(NUM_LEDS - 1), 8'h00, 8'hff, 8'h5a, '0);
    issue_command(OP_SET_COLOUR, IDX_IN_W'(NUM_LEDS), 8'hff, 8'hff, 8'hff, '0);
    issue_command(OP_SET_COLOUR, IDX_IN_W'(IDX_LAST), 8'hff, 8'hff, 8'hff, '1);
    issue_command(OP_SET_COLOUR, 6'd1, 8'h12, 8'h34, 8'h56, '0);
    issue_command(OP_SET_COLOUR, 6'd2, '1, '1, '1, '0);
    issue_command(OP_SET_LEVEL, '0, '0, '0, '0, LEVEL_W'(PWM_STEPS));
    issue_command(OP_SET_LEVEL, IDX_IN_W'(NUM_LEDS - 1), '0, '0, '0, LEVEL_W'(PWM_STEPS + 1));
    issue_command(OP_SET_LEVEL, 6'd1, '0, '0, '0, LEVEL_W'(LEVEL_LAST));
    issue_command(OP_SET_LEVEL, 6'd2, '0, '0, '0, '0);
    issue_command(OP_SET_LEVEL, IDX_IN_W'(IDX_LAST), '0, '0, '0, 8'd5);
    issue_command(OP_DIMMED, '0, '0, '0, '0, '0);
    issue_command(OP_PLAIN, '0, '0, '0, '0, '0);
    for (int op = int'(OP_PLAIN) + 1; op <= OP_LAST; op++)
      issue_command(OP_W'(op), '1, '1, '1, '1, '1);
    drain_pixels();
    issue_command(OP_CLEAR, '0, '0, '0, '0, '0);
    issue_command(OP_PLAIN, '0, '0, '0, '0, '0);
    issue_command(OP_SET_COLOUR, 6'd3, '1, '1, '1, '0);
    issue_command(OP_SET_LEVEL, 6'd3, '0, '0, '0, 8'd1);
    issue_command(OP_DIMMED, '0, '0, '0, '0, '0);
    hold_off(3);

    // Random: bursts of commands with random gaps, and a drain now and then
    effective  = 0;
    burst_left = 0;
    while (effective < RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 28)      r_op = OP_SET_COLOUR;
      else if (pick < 50) r_op = OP_SET_LEVEL;
      else if (pick < 53) r_op = OP_CLEAR;
      else if (pick < 75) r_op = OP_DIMMED;
      else if (pick < 90) r_op = OP_PLAIN;
      else                r_op = OP_W'($urandom_range(int'(OP_PLAIN) + 1, OP_LAST));
      r_idx = ($urandom_range(0, 9) == 0) ? IDX_IN_W'($urandom_range(NUM_LEDS, IDX_LAST))
                                          : IDX_IN_W'($urandom_range(0, NUM_LEDS - 1));
      r_lvl = ($urandom_range(0, 4) < 3) ? LEVEL_W'($urandom_range(0, PWM_STEPS))
                                         : LEVEL_W'($urandom_range(0, LEVEL_LAST));
      issue_command(r_op, r_idx, CH_W'($urandom_range(0, CH_LAST)),
                    CH_W'($urandom_range(0, CH_LAST)), CH_W'($urandom_range(0, CH_LAST)),
                    r_lvl);
      // writes past the chain and unknown codes do nothing; they don't count
      if (r_op == OP_CLEAR || r_op == OP_DIMMED || r_op == OP_PLAIN ||
          ((r_op == OP_SET_COLOUR || r_op == OP_SET_LEVEL) && int'(r_idx) < NUM_LEDS))
        effective++;
      if (effective % 120 == 119) begin
        drain_pixels();
      end else if (burst_left == 0) begin
        // occasional long stretch without idling
        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
        hold_off($urandom_range(1, NUM_LEDS + 6));
      end else begin
        burst_left--;
      end
    end

    // Wind down
    start <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (2 * NUM_LEDS + 8) @(posedge clk);
    if (shadow.pending() != 0)
      shadow.report_mismatch($sformatf("%0d pixels never arrived", shadow.pending()));

    $display("covered %0d commands: %0d frames, %0d dimmed, %0d phase wraps",
             shadow.commands_seen, shadow.frames_seen, shadow.dimmed_seen,
             shadow.phase_wraps);
    $display("checked %0d pixel transactions, %0d mismatches", shadow.pixels_checked,
             shadow.mismatch_count);
    if (shadow.mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/lfpd_pkg.sv
rtl/core/lfpd_cmd_fifo.sv
rtl/core/lfpd_front.sv
rtl/core/lfpd_back.sv
rtl/core/led_frame_pwm_dimmer.sv
dv/tb_led_frame_pwm_dimmer.sv
